// File: rtl/core/clsr_pkg.sv
package clsr_pkg;

  localparam int DEF_TABLE_ENTRIES = 32;
  localparam int WARMUP            = 8;
  localparam int PADDR_W           = 3;

  localparam logic [30:0] SEED_RESET = 31'd100000;
  localparam logic [30:0] MOD_ONE    = 31'd2147483563;
  localparam logic [30:0] MOD_TWO    = 31'd2147483399;
  localparam logic [30:0] TOP_DRAW   = 31'd2147483562;
  localparam logic [15:0] MUL_ONE    = 16'd40014;
  localparam logic [15:0] MUL_TWO    = 16'd40692;
  // 2^31 minus each modulus, used to fold the high product bits back in
  localparam logic [7:0]  FOLD_ONE   = 8'd85;
  localparam logic [7:0]  FOLD_TWO   = 8'd249;

  localparam logic [0:0]  REG_SEED   = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_WARM_MUL,
    ST_WARM_RED,
    ST_STEP_MUL,
    ST_STEP_RED,
    ST_INDEX,
    ST_READ,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic seed_load;
    logic warm_mul;
    logic warm_red;
    logic step_mul;
    logic step_red;
    logic index;
    logic read;
    logic mix;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
  } stat_t;

endpackage

// File: rtl/core/clsr_regs.sv
module clsr_regs import clsr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [30:0]        seed
);

  logic [0:0] reg_sel;

  assign reg_sel = paddr[PADDR_W-1 -: 1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_SEED) begin
      seed <= pwdata[30:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SEED: prdata = {1'b0, seed};
      default:  prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/clsr_ctrl.sv
module clsr_ctrl import clsr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   s_tvalid,
  input  logic   restart,
  output logic   s_tready,
  output logic   m_tvalid,
  input  logic   m_tready,
  output cmd_t   cmd,
  input  stat_t  stat
);

  state_t state;
  state_t state_next;
  logic   seeded;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seeded   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.warm_red && stat.fill_zero) begin
        seeded <= 1'b1;
      end
      if (cmd.mix) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (restart || !seeded) ? ST_SEED : ST_STEP_MUL;
        end
      end
      ST_SEED:     state_next = ST_WARM_MUL;
      ST_WARM_MUL: state_next = ST_WARM_RED;
      ST_WARM_RED: state_next = stat.fill_zero ? ST_STEP_MUL : ST_WARM_MUL;
      ST_STEP_MUL: state_next = ST_STEP_RED;
      ST_STEP_RED: state_next = ST_INDEX;
      ST_INDEX:    state_next = ST_READ;
      ST_READ:     state_next = ST_MIX;
      ST_MIX: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE:     s_tready     = 1'b1;
      ST_SEED:     cmd.seed_load = 1'b1;
      ST_WARM_MUL: cmd.warm_mul  = 1'b1;
      ST_WARM_RED: cmd.warm_red  = 1'b1;
      ST_STEP_MUL: cmd.step_mul  = 1'b1;
      ST_STEP_RED: cmd.step_red  = 1'b1;
      ST_INDEX:    cmd.index     = 1'b1;
      ST_READ:     cmd.read      = 1'b1;
      ST_MIX:      cmd.mix       = out_free;
      default:     cmd           = '0;
    endcase
  end

endmodule

// File: rtl/core/clsr_dp.sv
module clsr_dp import clsr_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [30:0] seed,
  output logic [30:0] draw
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int QW = $clog2(TABLE_ENTRIES + 1);
  localparam int FW = $clog2(TABLE_ENTRIES + WARMUP);
  localparam int PW = 31 + QW;
  localparam longint BucketL = 64'd1 + (64'(TOP_DRAW) / TABLE_ENTRIES);
  localparam longint RecipL  = (64'd1 << 31) / BucketL;
  localparam logic [30:0]   BUCKET   = 31'(BucketL);
  localparam logic [QW-1:0] RECIP    = QW'(RecipL);
  localparam logic [QW-1:0] ENTRIES  = QW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [FW-1:0] FILL_TOP = FW'(TABLE_ENTRIES + WARMUP - 1);
  localparam logic [FW-1:0] FILL_LIM = FW'(TABLE_ENTRIES);

  logic [30:0] mem [TABLE_ENTRIES];

  logic [30:0]   gen_one;
  logic [30:0]   gen_two;
  logic [30:0]   last_draw;
  logic [46:0]   prod_one;
  logic [46:0]   prod_two;
  logic [FW-1:0] fill_idx;
  logic [PW-1:0] qprod;
  logic [QW-1:0] q0;
  logic [PW-1:0] qb;
  logic [IW-1:0] idx;
  logic [30:0]   rd_data;

  logic [31:0]   fold_one;
  logic [31:0]   fold_two;
  logic [30:0]   red_one;
  logic [30:0]   red_two;
  logic [30:0]   seed_v;
  logic [PW-1:0] rem;
  logic [QW-1:0] q_fix;
  logic [IW-1:0] idx_next;
  logic [31:0]   diff;
  logic [30:0]   mix_val;
  logic          fill_wr;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [30:0]   mem_wdata;

  assign seed_v   = (seed == '0) ? 31'd1 : seed;
  assign fold_one = 32'(prod_one[30:0]) + 32'(prod_one[46:31]) * 32'(FOLD_ONE);
  assign fold_two = 32'(prod_two[30:0]) + 32'(prod_two[46:31]) * 32'(FOLD_TWO);
  assign red_one  = (fold_one >= 32'(MOD_ONE)) ? 31'(fold_one - 32'(MOD_ONE))
                                               : fold_one[30:0];
  assign red_two  = (fold_two >= 32'(MOD_TWO)) ? 31'(fold_two - 32'(MOD_TWO))
                                               : fold_two[30:0];

  assign rem = PW'(last_draw) - qb;

  always_comb begin
    q_fix = (rem >= PW'(BUCKET)) ? q0 + QW'(1) : q0;
    if (q_fix >= ENTRIES) begin
      idx_next = LAST_IDX;
    end else begin
      idx_next = q_fix[IW-1:0];
    end
  end

  always_comb begin
    diff = {1'b0, rd_data} - {1'b0, gen_two};
    if (diff[31] || diff == '0) begin
      diff = diff + 32'(TOP_DRAW);
    end
    mix_val = diff[30:0];
  end

  assign fill_wr        = cmd.warm_red && (fill_idx < FILL_LIM);
  assign mem_we         = fill_wr || cmd.mix;
  assign mem_addr       = cmd.mix ? idx : fill_idx[IW-1:0];
  assign mem_wdata      = cmd.mix ? gen_one : red_one;
  assign stat.fill_zero = (fill_idx == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      gen_one  <= seed_v;
      gen_two  <= seed_v;
      fill_idx <= FILL_TOP;
    end
    if (cmd.warm_mul || cmd.step_mul) begin
      prod_one <= 47'(gen_one) * 47'(MUL_ONE);
    end
    if (cmd.step_mul) begin
      prod_two <= 47'(gen_two) * 47'(MUL_TWO);
      qprod    <= PW'(last_draw) * PW'(RECIP);
    end
    if (cmd.warm_red || cmd.step_red) begin
      gen_one <= red_one;
    end
    if (cmd.warm_red) begin
      if (fill_idx == '0) begin
        last_draw <= red_one;
      end else begin
        fill_idx <= fill_idx - FW'(1);
      end
    end
    if (cmd.step_red) begin
      gen_two <= red_two;
      q0      <= qprod[PW-1:31];
      qb      <= PW'(qprod[PW-1:31]) * PW'(BUCKET);
    end
    if (cmd.index) begin
      idx <= idx_next;
    end
    if (cmd.mix) begin
      last_draw <= mix_val;
      draw      <= mix_val;
    end
  end

endmodule

// File: rtl/core/combined_lcg_shuffle_rng.sv
// Channel   Dir  Beat fields (tdata / tuser)           Handshake
// s_*       in   tdata[0] restart                       s_tvalid & s_tready
// m_*       out  tdata[30:0] draw                       m_tvalid & m_tready
// APB       in   reg 0 at 0x0: seed [30:0]              psel & penable & pwrite
//
// A draw runs the generator step (multiply, then fold and reduce), then index,
// table read and mix; the result is registered at the mix. s_tready is high
// only in idle, so a new beat goes in only once the previous draw is mixed.
// A reseed loads the seed and runs the generator-one steps that fill the table
// before the draw; it runs on the first beat after reset.
// Reset is synchronous; the table holds no reset value and is filled by reseed.
// A result waiting on m_tready stalls only the final mix; s_tready is up again
// as soon as the result sits in the output register.
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [0] restart, [7:1] zero
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata    // [30:0] draw, [31] zero
);

  cmd_t        cmd;
  stat_t       stat;
  logic [30:0] seed;
  logic [30:0] draw;

  clsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .restart  (s_tdata[0]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  clsr_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk  (clk),
    .cmd  (cmd),
    .stat (stat),
    .seed (seed),
    .draw (draw)
  );

  assign m_tdata = {1'b0, draw};

endmodule

// File: rtl/core/clsr_chk.sv
module clsr_chk import clsr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a draw is in progress");

  a_draw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:0] != '0 && m_tdata[30:0] <= TOP_DRAW && !m_tdata[31]))
    else $error("draw out of range");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a draw in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready dropped");

endmodule

bind combined_lcg_shuffle_rng clsr_chk u_chk (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import clsr_pkg::*;

  localparam int     TBL_N       = DEF_TABLE_ENTRIES;
  localparam longint QUO_ONE     = 53668;
  localparam longint QUO_TWO     = 52774;
  localparam longint REM_ONE     = 12211;
  localparam longint REM_TWO     = 3791;
  localparam longint BUCKET      = 1 + longint'(TOP_DRAW) / TBL_N;
  localparam int     STALL_LIMIT = 5000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     BLOCK_ITEMS = 100;
  localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'(4 * REG_SEED);

  typedef enum {PH_DIRECT, PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH, PH_PRESSURE} phase_t;

  logic               clk;
  logic               rst      = 1'b1;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;    // [0] restart, [7:1] zero
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;          // [30:0] draw, [31] zero

  phase_t      phase          = PH_DIRECT;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          hold_cnt       = 0;
  int          quiet_cycles   = 0;
  int          fail_cnt       = 0;
  logic        restart_q[$];
  logic [30:0] draw_q[$];
  logic [30:0] exp_draw;

  logic [30:0] seed_reg = SEED_RESET;
  longint      gen_a      = 0;
  longint      gen_b      = 0;
  longint      prev_draw  = 0;
  longint      shuf_tab[TBL_N];
  logic        seeded     = 1'b0;

  combined_lcg_shuffle_rng i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint lcg_step(longint z, longint a, longint q, longint r, longint m);
    longint k;
    longint v;
    k = z / q;
    v = a * (z - k * q) - k * r;
    if (v < 0) v += m;
    return v;
  endfunction

  function automatic void shuffle_reseed();
    longint v;
    v = longint'(seed_reg);
    if (v < 1) v = 1;
    gen_a = v;
    gen_b = v;
    for (int j = TBL_N + WARMUP - 1; j >= 0; j--) begin
      gen_a = lcg_step(gen_a, MUL_ONE, QUO_ONE, REM_ONE, MOD_ONE);
      if (j < TBL_N) shuf_tab[j] = gen_a;
    end
    prev_draw = shuf_tab[0];
    seeded = 1'b1;
  endfunction

  function automatic void draw_predict(logic restart);
    longint idx;
    longint d;
    if (restart || !seeded) shuffle_reseed();
    gen_a = lcg_step(gen_a, MUL_ONE, QUO_ONE, REM_ONE, MOD_ONE);
    gen_b = lcg_step(gen_b, MUL_TWO, QUO_TWO, REM_TWO, MOD_TWO);
    idx = prev_draw / BUCKET;
    if (idx < 0) idx = 0;
    if (idx >= TBL_N) idx = TBL_N - 1;
    d = shuf_tab[int'(idx)] - gen_b;
    shuf_tab[int'(idx)] = gen_a;
    if (d < 1) d += longint'(TOP_DRAW);
    prev_draw = d;
    draw_q.push_back(d[30:0]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) draw_predict(s_tdata[0]);
      if (!s_tvalid || s_tready) begin
        if (restart_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, restart_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // hold off the sink for a long stretch on entry to the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (phase != PH_PRESSURE) hold_cnt <= 0;
      else if (hold_cnt != HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
      m_tready <= (phase != PH_PRESSURE || hold_cnt == HOLD_CYCLES) &&
                  $urandom_range(99) >= sink_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (draw_q.size() == 0) begin
        $display("%0t: unexpected draw beat, expected none, actual %h", $time, m_tdata);
        fail_cnt++;
      end else begin
        exp_draw = draw_q.pop_front();
        if (m_tdata !== {1'b0, exp_draw}) begin
          $display("%0t: draw mismatch, expected %h, actual %h",
                   $time, {1'b0, exp_draw}, m_tdata);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic seed_write(logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_reg = value[30:0];
    @(negedge clk);
  endtask

  task automatic enter_phase(phase_t p, int src_pct, int sink_pct);
    phase          = p;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic drain();
    while (restart_q.size() != 0 || s_tvalid || draw_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return {1'b0, TOP_DRAW};
      2: return {1'b0, MOD_ONE};
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] dir_seeds[7];
    phase_t      rnd_phase[5];
    int          src_pct[5];
    int          sink_pct[5];
    dir_seeds = '{32'd0, {1'b0, TOP_DRAW}, {1'b0, MOD_ONE}, {1'b0, MOD_TWO},
                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1};
    rnd_phase = '{PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH, PH_PRESSURE};
    src_pct   = '{0, 49, 0, 33, 0};
    sink_pct  = '{0, 0, 49, 33, 33};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first beat after reset seeds from the reset value of the seed register
    enter_phase(PH_DIRECT, 0, 0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b0);
    restart_q.push_back(1'b1);
    restart_q.push_back(1'b0);
    drain();

    // a new seed takes effect only at the next restart
    foreach (dir_seeds[i]) begin
      seed_write(dir_seeds[i]);
      restart_q.push_back(1'b0);
      restart_q.push_back(1'b1);
      restart_q.push_back(1'b0);
      drain();
    end

    foreach (rnd_phase[p]) begin
      enter_phase(rnd_phase[p], src_pct[p], sink_pct[p]);
      for (int b = 0; b < 2; b++) begin
        seed_write(pick_seed());
        restart_q.push_back(1'b1);
        for (int n = 1; n < BLOCK_ITEMS; n++) restart_q.push_back($urandom_range(15) == 0);
        drain();
      end
    end

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
